/* rtl/awb_pkg.sv */
package awb_pkg;

   localparam int MinWidth       = 16;
   localparam int PeriodWidth    = 8;
   localparam int StreakWidth    = 8;
   localparam int OutcomeWidth   = 3;
   localparam int CsrIndexWidth  = 3;
   localparam int ShiftWidth     = 2 * MinWidth - 1;
   localparam int ShiftSelWidth  = $clog2(MinWidth);

   localparam logic [MinWidth-1:0]    MIN_SLEEP       = MinWidth'(5);
   localparam logic [StreakWidth-1:0] STREAK_MAX      = '1;

   localparam logic [MinWidth-1:0]    WAKE_RESET      = MinWidth'(60);
   localparam logic [MinWidth-1:0]    QUIET_MAX_RESET = MinWidth'(12 * 60);
   localparam logic [MinWidth-1:0]    ERR_BASE_RESET  = MinWidth'(15);
   localparam logic [MinWidth-1:0]    ERR_MAX_RESET   = MinWidth'(4 * 60);
   localparam logic [MinWidth-1:0]    BIND_RESET      = MinWidth'(5);
   localparam logic [MinWidth-1:0]    RETIRED_RESET   = MinWidth'(12 * 60);
   localparam logic [PeriodWidth-1:0] PERIOD_RESET    = PeriodWidth'(24);

   // outcome codes; codes above ERROR behave as ERROR
   localparam logic [OutcomeWidth-1:0] OUTCOME_OK        = 3'd0;
   localparam logic [OutcomeWidth-1:0] OUTCOME_UNCHANGED = 3'd1;
   localparam logic [OutcomeWidth-1:0] OUTCOME_BIND      = 3'd2;
   localparam logic [OutcomeWidth-1:0] OUTCOME_RETIRED   = 3'd3;
   localparam logic [OutcomeWidth-1:0] OUTCOME_ERROR     = 3'd4;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] REG_WAKE      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_QUIET_MAX = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_ERR_BASE  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_ERR_MAX   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_BIND      = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_RETIRED   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] REG_PERIOD    = 3'd6;

   typedef struct packed {
      logic [MinWidth-1:0]    wake_interval_min;
      logic [MinWidth-1:0]    quiet_max_min;
      logic [MinWidth-1:0]    error_base_min;
      logic [MinWidth-1:0]    error_max_min;
      logic [MinWidth-1:0]    bind_retry_min;
      logic [MinWidth-1:0]    retired_min;
      logic [PeriodWidth-1:0] battery_period;
   } cfg_type;

   typedef struct packed {
      logic [MinWidth-1:0] sleep_minutes;
      logic                post_battery;
      logic                mark_stable;
   } res_type;

endpackage

/* rtl/awb_csr.sv */
module awb_csr
   import awb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [MinWidth-1:0]      csr_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_WAKE:      cfg_in.wake_interval_min =
                              (csr_data < MIN_SLEEP) ? MIN_SLEEP : csr_data;
            REG_QUIET_MAX: cfg_in.quiet_max_min  = csr_data;
            REG_ERR_BASE:  cfg_in.error_base_min = csr_data;
            REG_ERR_MAX:   cfg_in.error_max_min  = csr_data;
            REG_BIND:      cfg_in.bind_retry_min = csr_data;
            REG_RETIRED:   cfg_in.retired_min    = csr_data;
            REG_PERIOD:    cfg_in.battery_period = csr_data[PeriodWidth-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wake_interval_min <= WAKE_RESET;
         cfg_ff.quiet_max_min     <= QUIET_MAX_RESET;
         cfg_ff.error_base_min    <= ERR_BASE_RESET;
         cfg_ff.error_max_min     <= ERR_MAX_RESET;
         cfg_ff.bind_retry_min    <= BIND_RESET;
         cfg_ff.retired_min       <= RETIRED_RESET;
         cfg_ff.battery_period    <= PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/awb_core.sv */
module awb_core
   import awb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic [OutcomeWidth-1:0] outcome,
   input  cfg_type                 cfg,
   output res_type                 res
);

   logic [StreakWidth-1:0] unchanged_ff, unchanged_in;
   logic [StreakWidth-1:0] failure_ff, failure_in;
   logic [StreakWidth-1:0] skips_ff, skips_in;

   logic [MinWidth-1:0]    base_sel, ceil_sel, fixed_min, minutes;
   logic [StreakWidth-1:0] steps_sel;
   logic                   use_backoff;
   logic [ShiftWidth-1:0]  shifted;
   logic                   big_shift;
   logic [MinWidth-1:0]    backoff_min;
   logic                   eligible, post;
   logic [StreakWidth:0]   skips_inc;

   // streak updates and operand selection for the shared shifter
   always_comb begin
      unchanged_in = '0;
      failure_in   = '0;
      use_backoff  = 1'b0;
      base_sel     = cfg.error_base_min;
      ceil_sel     = cfg.error_max_min;
      steps_sel    = failure_ff;
      fixed_min    = cfg.wake_interval_min;
      case (outcome)
         OUTCOME_OK: begin
            fixed_min = cfg.wake_interval_min;
         end
         OUTCOME_UNCHANGED: begin
            use_backoff  = 1'b1;
            base_sel     = cfg.wake_interval_min;
            ceil_sel     = cfg.quiet_max_min;
            steps_sel    = unchanged_ff;
            unchanged_in = (unchanged_ff == STREAK_MAX) ? unchanged_ff
                                                        : unchanged_ff + 1'b1;
         end
         OUTCOME_BIND: begin
            fixed_min = cfg.bind_retry_min;
         end
         OUTCOME_RETIRED: begin
            fixed_min = cfg.retired_min;
         end
         default: begin
            use_backoff = 1'b1;
            failure_in  = (failure_ff == STREAK_MAX) ? failure_ff
                                                     : failure_ff + 1'b1;
         end
      endcase
   end

   // min(base * 2^steps, ceiling); a nonzero base shifted 16 or more always tops out
   assign big_shift = (steps_sel[StreakWidth-1:ShiftSelWidth] != '0) && (base_sel != '0);
   assign shifted   = ShiftWidth'(base_sel) << steps_sel[ShiftSelWidth-1:0];
   assign backoff_min = (big_shift || (shifted > ShiftWidth'(ceil_sel)))
                        ? ceil_sel : shifted[MinWidth-1:0];

   assign minutes = use_backoff ? backoff_min : fixed_min;

   // heartbeat divider
   assign eligible  = (outcome == OUTCOME_OK) || (outcome == OUTCOME_UNCHANGED);
   assign skips_inc = {1'b0, skips_ff} + 1'b1;
   assign post      = eligible && (skips_inc >= {1'b0, cfg.battery_period});

   always_comb begin
      skips_in = skips_ff;
      if (post) begin
         skips_in = '0;
      end else if (eligible) begin
         skips_in = skips_inc[StreakWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unchanged_ff <= '0;
         failure_ff   <= '0;
         skips_ff     <= '1;
      end else if (fire) begin
         unchanged_ff <= unchanged_in;
         failure_ff   <= failure_in;
         skips_ff     <= skips_in;
      end
   end

   assign res.sleep_minutes = (minutes < MIN_SLEEP) ? MIN_SLEEP : minutes;
   assign res.post_battery  = post;
   assign res.mark_stable   = (outcome <= OUTCOME_RETIRED);

endmodule

/* rtl/adaptive_wake_backoff_unit.sv */
// Wake-interval scheduler.
// req channel: one beat per wake cycle carrying req_outcome (ok, unchanged,
//   bind, retired, error; undefined codes act as error).
// rsp channel: one beat per request with the next sleep interval in minutes
//   (never below 5), a battery-heartbeat flag and a stable mark.
// csr port: single-cycle writes of the seven scheduling registers by index;
//   writes to an unused index are dropped. Write only while idle.
// Path: the request beat lands in the input register, then the result
//   register loads the result and rsp_valid rises. Throughput: one beat
//   per cycle while rsp_ready is high; the whole computation (one 16-bit
//   barrel shift plus compare, counter updates) sits between the two
//   registers.
// Stall: while rsp_ready is low the result holds and one more request can
//   still be taken into the input register; req_ready then drops.
// Reset (synchronous): both registers empty, streak counters zero, the
//   heartbeat counter all ones so the first eligible cycle reports, and
//   the scheduling registers return to their defaults.
module adaptive_wake_backoff_unit
   import awb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OutcomeWidth-1:0]  req_outcome,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [MinWidth-1:0]      rsp_sleep_minutes,
   output logic                     rsp_post_battery,
   output logic                     rsp_mark_stable,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [MinWidth-1:0]      csr_data
);

   cfg_type cfg;
   res_type res;

   logic                    in_valid_ff;
   logic [OutcomeWidth-1:0] in_outcome_ff;
   logic                    out_valid_ff;
   res_type                 out_res_ff;
   logic                    advance;   // input beat moves into the result register

   awb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // streak state updates on the same edge the result is captured,
   // so the next beat in line already sees it
   awb_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .outcome (in_outcome_ff),
      .cfg     (cfg),
      .res     (res)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_outcome_ff <= req_outcome;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_sleep_minutes = out_res_ff.sleep_minutes;
   assign rsp_post_battery  = out_res_ff.post_battery;
   assign rsp_mark_stable   = out_res_ff.mark_stable;

   // a result never goes below the floor
   a_min_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sleep_minutes >= MIN_SLEEP))
      else $error("sleep interval below floor");

   // error cycles never post a heartbeat
   a_err_no_post: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_mark_stable) |-> !rsp_post_battery)
      else $error("heartbeat on error cycle");

   // a pending input with room downstream shows up as a result next cycle
   a_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced beat lost");

   // backpressure only when both registers are full and the sink stalls
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("request refused without a stall");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import awb_pkg::*;

   // codes 5..7 are undefined and must behave as an error outcome
   localparam logic [OutcomeWidth-1:0]  OUTCOME_TOP = 3'd7;
   // index past the register list, writes to it are dropped
   localparam logic [CsrIndexWidth-1:0] REG_SPARE   = 3'd7;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [OutcomeWidth-1:0]  req_outcome = OUTCOME_OK;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [MinWidth-1:0]      rsp_sleep_minutes;
   logic                     rsp_post_battery;
   logic                     rsp_mark_stable;
   logic                     csr_write = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = REG_WAKE;
   logic [MinWidth-1:0]      csr_data = '0;

   adaptive_wake_backoff_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_outcome       (req_outcome),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sleep_minutes (rsp_sleep_minutes),
      .rsp_post_battery  (rsp_post_battery),
      .rsp_mark_stable   (rsp_mark_stable),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Shadow of the scheduler: registers, streak counters, heartbeat.
   // ---------------------------------------------------------------
   cfg_type                sched_cfg;
   logic [StreakWidth-1:0] quiet_run;
   logic [StreakWidth-1:0] fail_run;
   logic [PeriodWidth-1:0] beat_gap;

   logic [OutcomeWidth-1:0] outcome_backlog[$];   // outcomes not yet offered
   res_type                 sleep_forecasts[$];   // predicted rsp beats, oldest first

   int  mismatch_count = 0;
   int  rsp_beats = 0;
   bit  sender_idle_on = 1'b1;
   bit  receiver_idle_on = 1'b1;

   // Doubling from base, once per earlier cycle of the streak, while
   // below the ceiling; clamps to the ceiling when it would overshoot.
   function automatic logic [MinWidth-1:0] backed_off(input logic [MinWidth-1:0] base,
                                                      input logic [StreakWidth-1:0] steps,
                                                      input logic [MinWidth-1:0] ceiling);
      int unsigned m;
      int unsigned i;
      bit          capped;
      m = base;
      capped = 1'b0;
      for (i = 0; i < steps && m < ceiling && !capped; i++) begin
         if (m > ceiling / 2) capped = 1'b1;
         else m = m * 2;
      end
      if (capped || m > ceiling) m = ceiling;
      return m[MinWidth-1:0];
   endfunction

   // Advances the shadow state by one wake cycle and returns the rsp beat.
   function automatic res_type forecast_sleep(input logic [OutcomeWidth-1:0] outcome);
      res_type             r;
      logic [MinWidth-1:0] minutes;
      bit                  eligible;
      bit                  post;
      eligible = (outcome == OUTCOME_OK) || (outcome == OUTCOME_UNCHANGED);
      post = 1'b0;
      case (outcome)
         OUTCOME_OK: begin
            quiet_run = '0;
            fail_run = '0;
            minutes = sched_cfg.wake_interval_min;
         end
         OUTCOME_UNCHANGED: begin
            fail_run = '0;
            minutes = backed_off(sched_cfg.wake_interval_min, quiet_run,
                                 sched_cfg.quiet_max_min);
            if (quiet_run != STREAK_MAX) quiet_run++;
         end
         OUTCOME_BIND: begin
            quiet_run = '0;
            fail_run = '0;
            minutes = sched_cfg.bind_retry_min;
         end
         OUTCOME_RETIRED: begin
            quiet_run = '0;
            fail_run = '0;
            minutes = sched_cfg.retired_min;
         end
         default: begin
            // error and every undefined code
            quiet_run = '0;
            minutes = backed_off(sched_cfg.error_base_min, fail_run,
                                 sched_cfg.error_max_min);
            if (fail_run != STREAK_MAX) fail_run++;
         end
      endcase
      if (eligible) begin
         if (beat_gap >= sched_cfg.battery_period) begin
            post = 1'b1;
         end else begin
            beat_gap++;
            post = (beat_gap >= sched_cfg.battery_period);
         end
         if (post) beat_gap = '0;
      end
      r.sleep_minutes = (minutes < MIN_SLEEP) ? MIN_SLEEP : minutes;
      r.post_battery  = post;
      r.mark_stable   = (outcome <= OUTCOME_RETIRED);
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Request driver: offers backlog outcomes, random gaps between beats.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      bit free;
      int send_gap;
      if (reset) begin
         req_valid <= 1'b0;
         req_outcome <= OUTCOME_OK;
         send_gap = 0;
      end else begin
         free = !req_valid;
         if (req_valid && req_ready) begin
            sleep_forecasts.push_back(forecast_sleep(req_outcome));
            free = 1'b1;
         end
         if (free) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (outcome_backlog.size() > 0) begin
               req_valid <= 1'b1;
               req_outcome <= outcome_backlog.pop_front();
               if (sender_idle_on && $urandom_range(0, 3) == 0)
                  send_gap = $urandom_range(1, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Response monitor: checks each beat against the oldest forecast,
   // random back-pressure plus two long holds that fill the pipe.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : watch_rsp
      res_type want;
      int      stall;
      int      hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall = 0;
         hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_beats++;
            if (sleep_forecasts.size() == 0) begin
               $error("unexpected rsp beat: sleep_minutes %0d", rsp_sleep_minutes);
               mismatch_count++;
            end else begin
               want = sleep_forecasts.pop_front();
               if (rsp_sleep_minutes !== want.sleep_minutes) begin
                  $error("sleep_minutes: expected %0d, actual %0d",
                         want.sleep_minutes, rsp_sleep_minutes);
                  mismatch_count++;
               end
               if (rsp_post_battery !== want.post_battery) begin
                  $error("post_battery: expected %0b, actual %0b",
                         want.post_battery, rsp_post_battery);
                  mismatch_count++;
               end
               if (rsp_mark_stable !== want.mark_stable) begin
                  $error("mark_stable: expected %0b, actual %0b",
                         want.mark_stable, rsp_mark_stable);
                  mismatch_count++;
               end
            end
            // long hold while the driver keeps pushing: req_ready must drop
            if (rsp_beats == 300 || rsp_beats == 1100) hold = 90;
         end
         if (hold > 0) hold--;
         else if (stall > 0) stall--;
         else if (receiver_idle_on && $urandom_range(0, 3) == 0)
            stall = $urandom_range(1, 7);
         rsp_ready <= (hold == 0 && stall == 0);
      end
   end

   // ---------------------------------------------------------------
   // Register writes, only with nothing in flight. The shadow copy is
   // updated as the write is issued.
   // ---------------------------------------------------------------
   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx,
                            input logic [MinWidth-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         REG_WAKE:      sched_cfg.wake_interval_min = (val < MIN_SLEEP) ? MIN_SLEEP : val;
         REG_QUIET_MAX: sched_cfg.quiet_max_min = val;
         REG_ERR_BASE:  sched_cfg.error_base_min = val;
         REG_ERR_MAX:   sched_cfg.error_max_min = val;
         REG_BIND:      sched_cfg.bind_retry_min = val;
         REG_RETIRED:   sched_cfg.retired_min = val;
         REG_PERIOD:    sched_cfg.battery_period = val[PeriodWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_schedule(input logic [MinWidth-1:0] wake,
                                 input logic [MinWidth-1:0] quiet_max,
                                 input logic [MinWidth-1:0] err_base,
                                 input logic [MinWidth-1:0] err_max,
                                 input logic [MinWidth-1:0] bind_retry,
                                 input logic [MinWidth-1:0] retired,
                                 input logic [MinWidth-1:0] period);
      write_csr(REG_WAKE, wake);
      write_csr(REG_QUIET_MAX, quiet_max);
      write_csr(REG_ERR_BASE, err_base);
      write_csr(REG_ERR_MAX, err_max);
      write_csr(REG_BIND, bind_retry);
      write_csr(REG_RETIRED, retired);
      write_csr(REG_PERIOD, period);
      write_csr(REG_SPARE, 16'($urandom));
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // interval register value: tiny, moderate, anything, or the top
   function automatic logic [MinWidth-1:0] pick_minutes();
      logic [MinWidth-1:0] v;
      case ($urandom_range(0, 3))
         0:       v = 16'($urandom_range(0, 8));
         1:       v = 16'($urandom_range(1, 200));
         2:       v = 16'($urandom);
         default: v = 16'hFFFF;
      endcase
      return v;
   endfunction

   // period sits in the low byte; upper bits are noise the block must drop
   function automatic logic [MinWidth-1:0] pick_period();
      logic [PeriodWidth-1:0] p;
      case ($urandom_range(0, 3))
         0:       p = 8'($urandom_range(0, 3));
         1:       p = 8'($urandom_range(4, 40));
         2:       p = 8'($urandom);
         default: p = 8'hFF;
      endcase
      return {8'($urandom), p};
   endfunction

   // sender pause: nothing offered until every forecast has been matched
   task automatic await_drain();
      do @(negedge clock);
      while (outcome_backlog.size() != 0 || req_valid || sleep_forecasts.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // a streak of one outcome class; error streaks mix in undefined codes
   task automatic queue_run(input logic [OutcomeWidth-1:0] code, input int len);
      repeat (len) begin
         if (code >= OUTCOME_ERROR && $urandom_range(0, 3) == 0)
            outcome_backlog.push_back(3'($urandom_range(OUTCOME_ERROR + 1, OUTCOME_TOP)));
         else if (code >= OUTCOME_ERROR)
            outcome_backlog.push_back(OUTCOME_ERROR);
         else
            outcome_backlog.push_back(code);
      end
   endtask

   // mostly streaks with random lengths, some singles and raw noise
   task automatic queue_wake_traffic(input int count);
      int queued;
      int len;
      queued = 0;
      while (queued < count) begin
         len = 1;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               len = $urandom_range(1, 12);
               queue_run(OUTCOME_UNCHANGED, len);
            end
            4, 5: begin
               len = $urandom_range(1, 10);
               queue_run(OUTCOME_ERROR, len);
            end
            6:       outcome_backlog.push_back(OUTCOME_OK);
            7:       outcome_backlog.push_back($urandom_range(0, 1) ? OUTCOME_BIND
                                                                    : OUTCOME_RETIRED);
            default: outcome_backlog.push_back(3'($urandom_range(0, OUTCOME_TOP)));
         endcase
         queued += len;
      end
   endtask

   initial begin : stimulus
      int ph;
      sched_cfg.wake_interval_min = WAKE_RESET;
      sched_cfg.quiet_max_min     = QUIET_MAX_RESET;
      sched_cfg.error_base_min    = ERR_BASE_RESET;
      sched_cfg.error_max_min     = ERR_MAX_RESET;
      sched_cfg.bind_retry_min    = BIND_RESET;
      sched_cfg.retired_min       = RETIRED_RESET;
      sched_cfg.battery_period    = PERIOD_RESET;
      quiet_run = '0;
      fail_run  = '0;
      beat_gap  = '1;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: first eligible cycle posts a heartbeat, unchanged
      // doubles up to the quiet ceiling, errors double up to the error
      // ceiling, undefined codes continue the error streak.
      outcome_backlog.push_back(OUTCOME_OK);
      queue_run(OUTCOME_UNCHANGED, 5);
      outcome_backlog.push_back(OUTCOME_BIND);
      outcome_backlog.push_back(OUTCOME_RETIRED);
      outcome_backlog.push_back(OUTCOME_ERROR);
      outcome_backlog.push_back(OUTCOME_ERROR);
      outcome_backlog.push_back(3'd5);
      outcome_backlog.push_back(3'd6);
      outcome_backlog.push_back(OUTCOME_TOP);
      outcome_backlog.push_back(OUTCOME_OK);
      await_drain();

      // Zeros (retired at one): wake clamps to the floor on write, zero ceilings and
      // fixed intervals still give the floor, zero period posts every time.
      apply_schedule(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'hFF00);
      queue_run(OUTCOME_UNCHANGED, 2);
      queue_run(OUTCOME_ERROR, 2);
      outcome_backlog.push_back(OUTCOME_BIND);
      outcome_backlog.push_back(OUTCOME_RETIRED);
      outcome_backlog.push_back(OUTCOME_OK);
      await_drain();

      // Top of every range but the error base, which is one; random traffic on it.
      apply_schedule(16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF);
      queue_wake_traffic(120);
      await_drain();

      // Random settings per phase; idling toggles per phase and is off in
      // the last one. Phase one carries streaks long enough to saturate.
      for (ph = 0; ph < 5; ph++) begin
         sender_idle_on   = (ph != 4) && ($urandom_range(0, 3) != 0);
         receiver_idle_on = (ph != 4) && ($urandom_range(0, 3) != 0);
         apply_schedule(pick_minutes(), pick_minutes(), pick_minutes(), pick_minutes(),
                        pick_minutes(), pick_minutes(), pick_period());
         if (ph == 1) begin
            queue_run(OUTCOME_UNCHANGED, $urandom_range(258, 270));
            outcome_backlog.push_back(OUTCOME_OK);
            queue_run(OUTCOME_ERROR, $urandom_range(258, 270));
         end
         queue_wake_traffic(200);
         await_drain();
      end

      repeat (6) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // run bound, far beyond the slowest legal run
   initial begin : watchdog
      #4_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
